### src/slgs_pkg.sv
// ---------------------------------------------------------------------------
// slgs_pkg: shared constants and types for the gradient step core
// Fixed-point widths, model constants, register indexes and the words that
// travel between the front and back parts.
// ---------------------------------------------------------------------------
package slgs_pkg;

	localparam int FRAC_BITS = 9;

	// field widths
	localparam int W_C  = 24;              // coordinates and config registers
	localparam int W_RD = 22;              // light reading
	localparam int W_DC = W_C + 1;         // coordinate minus node
	localparam int W_SQ = 2 * W_C;         // one squared term
	localparam int W_N2 = W_SQ + 2;        // sum of three squares
	localparam int W_G  = 42;              // distance term g
	localparam int W_GH = W_G / 2;         // half of g for the square
	localparam int W_PP = 2 * W_GH;        // partial product of g * g
	localparam int W_W  = 64;              // model word
	localparam int W_FN = 34;              // numerator of f
	localparam int W_F  = 19;              // quotient bits of f (g >= 48 << FRAC_BITS)
	localparam int W_DF = W_C;             // reading minus f
	localparam int W_AD = 49;              // A * (reading - f)
	localparam int W_AL = 24;              // low slice of that product
	localparam int W_PL = 2 * W_DC;        // partial products of the numerator
	localparam int Q_BITS = W_W;           // quotient bits of the step division

	// pipeline length of the back part, from queue pop to last stage
	localparam int N_STG = W_F + Q_BITS + 8;

	// entries of the queue between front and back
	localparam int Q_DEPTH = 4;

	// model constants
	localparam logic [W_G-1:0]         B_TERM = W_G'(48) << FRAC_BITS;
	localparam logic [W_FN-1:0]        F_NUM  = W_FN'(48000) << (2 * FRAC_BITS);
	localparam logic signed [W_AD-1:0] A_TERM = W_AD'(48000) << FRAC_BITS;
	localparam logic [W_C-1:0]         MIN_RST = W_C'(-(30 << FRAC_BITS));
	localparam logic [W_C-1:0]         MAX_RST = W_C'(90 << FRAC_BITS);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_NODE_COL,
		REG_NODE_ROW,
		REG_MIN_X,
		REG_MAX_X,
		REG_MIN_Y,
		REG_MAX_Y
	} cfg_reg_t;

	// classified input word, front to back
	typedef struct packed {
		logic signed [W_C-1:0]  x;
		logic signed [W_C-1:0]  y;
		logic signed [W_C-1:0]  h;
		logic signed [W_RD-1:0] rd;
		logic signed [W_DC-1:0] dx;
		logic signed [W_DC-1:0] dy;
	} item_t;

	// clamp box
	typedef struct packed {
		logic signed [W_C-1:0] min_x;
		logic signed [W_C-1:0] max_x;
		logic signed [W_C-1:0] min_y;
		logic signed [W_C-1:0] max_y;
	} bounds_t;

	// result word
	typedef struct packed {
		logic [W_C-1:0] nx;
		logic [W_C-1:0] ny;
		logic [W_C-1:0] h;
	} res_t;

endpackage

### src/source_location_gradient_step_core.sv
// ---------------------------------------------------------------------------
// source_location_gradient_step_core: one gradient step toward a light source
// Input words carry a position estimate and a light reading; each gives one
// output word with the stepped, box-clamped x and y and the height unchanged.
// Channels use valid/stall; a word moves on an edge with valid high, stall low.
// Configuration: write cfg_data to register cfg_index while cfg_we is high,
// only while no word is in flight. Indexes above five are ignored.
// Throughput: one word per cycle while out_stall stays low. The pipeline holds
// the 19-stage f divider and the 64-stage step dividers.
// A four-word queue sits between the input side and the pipeline; a two-word
// output buffer sits at the end. When the receiver stalls, the buffer fills,
// the pipeline freezes, the queue fills, then in_stall rises.
// Reset (arst_n low) empties queue, pipeline and buffer and loads the default
// node position and clamp box.
// ---------------------------------------------------------------------------
module source_location_gradient_step_core import slgs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [W_C-1:0]         cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [W_C-1:0]  pos_x,
	input  logic signed [W_C-1:0]  pos_y,
	input  logic signed [W_C-1:0]  pos_h,
	input  logic signed [W_RD-1:0] light_reading,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [W_C-1:0]  new_x,
	output logic signed [W_C-1:0]  new_y,
	output logic signed [W_C-1:0]  new_h
);

	logic    q_valid, q_pop;
	item_t   q_item;
	bounds_t bounds;

	slgs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_h         (pos_h),
		.light_reading (light_reading),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.bounds        (bounds)
	);

	slgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.bounds    (bounds),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_x     (new_x),
		.new_y     (new_y),
		.new_h     (new_h)
	);

endmodule

### src/slgs_recip.sv
// ---------------------------------------------------------------------------
// slgs_recip: pipelined restoring divider for f = (A << FRAC_BITS) / g
// One quotient bit per stage, W_F stages; the numerator is a constant.
// ---------------------------------------------------------------------------
module slgs_recip import slgs_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [W_G-1:0]  den,
	output logic [W_F-1:0]  quo
);

	logic [W_FN-1:0] rem_q [W_F];
	logic [W_G-1:0]  den_q [W_F];
	logic [W_F-1:0]  quo_q [W_F];

	logic [W_FN-1:0] p_rem [W_F];
	logic [W_G-1:0]  p_den [W_F];
	logic [W_F-1:0]  p_quo [W_F];
	logic [W_FN-1:0] n_rem [W_F];
	logic [W_F-1:0]  n_quo [W_F];
	logic [W_W-1:0]  trial [W_F];
	logic            ge    [W_F];

	// one trial subtraction per stage, highest quotient bit first
	always_comb begin
		for (int k = 0; k < W_F; k++) begin
			if (k == 0) begin
				p_rem[k] = F_NUM;
				p_den[k] = den;
				p_quo[k] = '0;
			end else begin
				p_rem[k] = rem_q[k-1];
				p_den[k] = den_q[k-1];
				p_quo[k] = quo_q[k-1];
			end
			trial[k] = W_W'(p_den[k]) << (W_F - 1 - k);
			ge[k]    = W_W'(p_rem[k]) >= trial[k];
			n_rem[k] = ge[k] ? (p_rem[k] - trial[k][W_FN-1:0]) : p_rem[k];
			n_quo[k] = p_quo[k];
			n_quo[k][W_F-1-k] = ge[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < W_F; k++) begin
				rem_q[k] <= n_rem[k];
				den_q[k] <= p_den[k];
				quo_q[k] <= n_quo[k];
			end
		end
	end

	assign quo = quo_q[W_F-1];

endmodule

### src/slgs_qdiv.sv
// ---------------------------------------------------------------------------
// slgs_qdiv: pipelined unsigned 64 by 64 restoring divider
// One quotient bit per stage; the dividend shifts out as quotient bits enter.
// ---------------------------------------------------------------------------
module slgs_qdiv import slgs_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [W_W-1:0]  num,
	input  logic [W_W-1:0]  den,
	output logic [W_W-1:0]  quo
);

	logic [W_W-1:0] rem_q [Q_BITS];
	logic [W_W-1:0] aq_q  [Q_BITS];
	logic [W_W-1:0] den_q [Q_BITS];

	logic [W_W-1:0] p_rem [Q_BITS];
	logic [W_W-1:0] p_aq  [Q_BITS];
	logic [W_W-1:0] p_den [Q_BITS];
	logic [W_W:0]   sh    [Q_BITS];
	logic [W_W:0]   dif   [Q_BITS];
	logic           ge    [Q_BITS];

	// shift in the next dividend bit, subtract when it fits
	always_comb begin
		for (int k = 0; k < Q_BITS; k++) begin
			if (k == 0) begin
				p_rem[k] = '0;
				p_aq[k]  = num;
				p_den[k] = den;
			end else begin
				p_rem[k] = rem_q[k-1];
				p_aq[k]  = aq_q[k-1];
				p_den[k] = den_q[k-1];
			end
			sh[k]  = {p_rem[k], p_aq[k][W_W-1]};
			dif[k] = sh[k] - {1'b0, p_den[k]};
			ge[k]  = sh[k] >= {1'b0, p_den[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_BITS; k++) begin
				rem_q[k] <= ge[k] ? dif[k][W_W-1:0] : sh[k][W_W-1:0];
				aq_q[k]  <= {p_aq[k][W_W-2:0], ge[k]};
				den_q[k] <= p_den[k];
			end
		end
	end

	assign quo = aq_q[Q_BITS-1];

endmodule

### src/slgs_front.sv
// ---------------------------------------------------------------------------
// slgs_front: configuration registers, input accept and word queue
// Offsets the estimate from the node position and queues the word for the
// back part, so input and output sides stall independently.
// ---------------------------------------------------------------------------
module slgs_front import slgs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [W_C-1:0]         cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [W_C-1:0]  pos_x,
	input  logic signed [W_C-1:0]  pos_y,
	input  logic signed [W_C-1:0]  pos_h,
	input  logic signed [W_RD-1:0] light_reading,
	output logic                   q_valid,
	output item_t                  q_item,
	input  logic                   q_pop,
	output bounds_t                bounds
);

	localparam int QA = $clog2(Q_DEPTH);
	localparam logic [QA:0] Q_FULL = (QA + 1)'(Q_DEPTH);

	logic [W_C-1:0] node_col_q, node_row_q;
	bounds_t        bounds_q;

	item_t          qmem_q [Q_DEPTH];
	logic [QA-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QA:0]    cnt_q;
	logic           push;
	item_t          word;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_col_q     <= '0;
			node_row_q     <= '0;
			bounds_q.min_x <= MIN_RST;
			bounds_q.max_x <= MAX_RST;
			bounds_q.min_y <= MIN_RST;
			bounds_q.max_y <= MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NODE_COL: node_col_q     <= cfg_data;
				REG_NODE_ROW: node_row_q     <= cfg_data;
				REG_MIN_X:    bounds_q.min_x <= cfg_data;
				REG_MAX_X:    bounds_q.max_x <= cfg_data;
				REG_MIN_Y:    bounds_q.min_y <= cfg_data;
				REG_MAX_Y:    bounds_q.max_y <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bounds = bounds_q;

	// build the word: offsets from the node
	always_comb begin
		word.x  = pos_x;
		word.y  = pos_y;
		word.h  = pos_h;
		word.rd = light_reading;
		word.dx = {pos_x[W_C-1], pos_x} - {node_col_q[W_C-1], node_col_q};
		word.dy = {pos_y[W_C-1], pos_y} - {node_row_q[W_C-1], node_row_q};
	end

	assign in_stall = (cnt_q == Q_FULL);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = qmem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			qmem_q[wr_ptr_q] <= word;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/slgs_back.sv
// ---------------------------------------------------------------------------
// slgs_back: arithmetic pipeline and output buffer
// Distance term, f divider, numerators, step divider, step and clamp, then a
// two-entry output buffer. The whole pipeline advances while the buffer has
// room.
// ---------------------------------------------------------------------------
module slgs_back import slgs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	input  bounds_t               bounds,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [W_C-1:0]        new_x,
	output logic [W_C-1:0]        new_y,
	output logic [W_C-1:0]        new_h
);

	localparam int W_EXT = W_W - W_PL;
	localparam int W_CX  = W_W - W_C;

	typedef struct packed {
		logic signed [W_C-1:0] x;
		logic signed [W_C-1:0] y;
		logic signed [W_C-1:0] h;
		logic                  neg_x;
		logic                  neg_y;
		logic                  zero;
	} dside_t;

	logic               en;
	logic [N_STG-1:0]   vld_q;

	// stage 1: squares
	logic signed [W_PL-1:0] px_c, py_c;
	logic signed [W_SQ-1:0] ph_c;
	item_t                  it_s1;
	logic [W_SQ-1:0]        sqx_s1, sqy_s1, sqh_s1;
	// stage 2: g
	logic [W_N2-1:0]        n2_c;
	item_t                  it_s2;
	logic [W_G-1:0]         g_s2;
	// stages 3, 4: g squared
	logic [W_PP-1:0]        pphh_s3, pphl_s3, ppll_s3;
	logic [W_W-1:0]         gsum_c;
	logic signed [W_W-1:0]  gsq_s4;
	logic signed [W_W-1:0]  gsq_d_q [W_F-2];
	item_t                  fside_q [W_F];
	logic [W_F-1:0]         f_w;
	// stage 5: A * (reading - f)
	item_t                  fi;
	logic signed [W_DF-1:0] diff_c;
	logic signed [W_AD-1:0] ad_c, ad_s5;
	item_t                  it_s5;
	logic signed [W_W-1:0]  gsq_s5;
	// stage 6: numerator partial products
	logic signed [W_PL-1:0] plx_c, phx_c, ply_c, phy_c;
	logic signed [W_PL-1:0] plx_s6, phx_s6, ply_s6, phy_s6;
	item_t                  it_s6;
	logic signed [W_W-1:0]  gsq_s6;
	// stage 7: numerators
	logic [W_W-1:0]         numx_s7, numy_s7;
	item_t                  it_s7;
	logic signed [W_W-1:0]  gsq_s7;
	// stage 8: magnitudes and signs
	logic [W_W-1:0]         magx_s8, magy_s8, magb_s8;
	dside_t                 ds_s8;
	dside_t                 dside_q [Q_BITS];
	logic [W_W-1:0]         qmx_w, qmy_w;
	// stage 9: signed quotients
	logic signed [W_W-1:0]  qx_s9, qy_s9;
	dside_t                 ds_s9;
	// stage 10: stepped coordinates
	logic signed [W_W-1:0]  tx_c, ty_c;
	logic signed [W_W-1:0]  nx_s10, ny_s10;
	logic [W_C-1:0]         h_s10;
	// clamp
	logic signed [W_W-1:0]  lox, hix, loy, hiy, cx_c, cy_c;
	res_t                   res_c;
	// output buffer
	res_t                   ob_q [2];
	logic                   ob_wr_q, ob_rd_q;
	logic [1:0]             ob_cnt_q;
	logic                   ob_push, ob_pop;

	// advance while the output buffer is not full
	assign en    = (ob_cnt_q != 2'd2);
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N_STG-2:0], q_valid};
		end
	end

	// stage 1
	assign px_c = q_item.dx * q_item.dx;
	assign py_c = q_item.dy * q_item.dy;
	assign ph_c = q_item.h * q_item.h;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= q_item;
			sqx_s1 <= px_c[W_SQ-1:0];
			sqy_s1 <= py_c[W_SQ-1:0];
			sqh_s1 <= ph_c;
		end
	end

	// stage 2
	assign n2_c = W_N2'(sqx_s1) + W_N2'(sqy_s1) + W_N2'(sqh_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			g_s2  <= W_G'(n2_c >> FRAC_BITS) + B_TERM;
		end
	end

	// f divider
	slgs_recip u_recip (
		.clk (clk),
		.en  (en),
		.den (g_s2),
		.quo (f_w)
	);

	// stages 3 and 4: low word of g * g, shifted
	assign gsum_c = (W_W'(pphh_s3) << (2 * W_GH)) + (W_W'(pphl_s3) << (W_GH + 1))
		+ W_W'(ppll_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			pphh_s3 <= g_s2[W_G-1:W_GH] * g_s2[W_G-1:W_GH];
			pphl_s3 <= g_s2[W_G-1:W_GH] * g_s2[W_GH-1:0];
			ppll_s3 <= g_s2[W_GH-1:0] * g_s2[W_GH-1:0];
			gsq_s4  <= $signed(gsum_c) >>> FRAC_BITS;
		end
	end

	// delay lines alongside the f divider
	always_ff @(posedge clk) begin
		if (en) begin
			fside_q[0] <= it_s2;
			for (int k = 1; k < W_F; k++) begin
				fside_q[k] <= fside_q[k-1];
			end
			gsq_d_q[0] <= gsq_s4;
			for (int k = 1; k < W_F - 2; k++) begin
				gsq_d_q[k] <= gsq_d_q[k-1];
			end
		end
	end

	// stage 5
	assign fi     = fside_q[W_F-1];
	assign diff_c = {{(W_DF - W_RD){fi.rd[W_RD-1]}}, fi.rd} - {{(W_DF - W_F){1'b0}}, f_w};
	assign ad_c   = diff_c * A_TERM;

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s5  <= ad_c;
			it_s5  <= fi;
			gsq_s5 <= gsq_d_q[W_F-3];
		end
	end

	// stage 6
	assign plx_c = $signed({1'b0, ad_s5[W_AL-1:0]}) * it_s5.dx;
	assign phx_c = $signed(ad_s5[W_AD-1:W_AL]) * it_s5.dx;
	assign ply_c = $signed({1'b0, ad_s5[W_AL-1:0]}) * it_s5.dy;
	assign phy_c = $signed(ad_s5[W_AD-1:W_AL]) * it_s5.dy;

	always_ff @(posedge clk) begin
		if (en) begin
			plx_s6 <= plx_c;
			phx_s6 <= phx_c;
			ply_s6 <= ply_c;
			phy_s6 <= phy_c;
			it_s6  <= it_s5;
			gsq_s6 <= gsq_s5;
		end
	end

	// stage 7: wrapped 64-bit numerators
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s7 <= ({{W_EXT{phx_s6[W_PL-1]}}, phx_s6} << W_AL)
				+ {{W_EXT{plx_s6[W_PL-1]}}, plx_s6};
			numy_s7 <= ({{W_EXT{phy_s6[W_PL-1]}}, phy_s6} << W_AL)
				+ {{W_EXT{ply_s6[W_PL-1]}}, ply_s6};
			it_s7   <= it_s6;
			gsq_s7  <= gsq_s6;
		end
	end

	// stage 8: sign and magnitude for the divider
	always_ff @(posedge clk) begin
		if (en) begin
			magx_s8     <= numx_s7[W_W-1] ? (W_W'(0) - numx_s7) : numx_s7;
			magy_s8     <= numy_s7[W_W-1] ? (W_W'(0) - numy_s7) : numy_s7;
			magb_s8     <= gsq_s7[W_W-1] ? (W_W'(0) - W_W'(gsq_s7)) : W_W'(gsq_s7);
			ds_s8.x     <= it_s7.x;
			ds_s8.y     <= it_s7.y;
			ds_s8.h     <= it_s7.h;
			ds_s8.neg_x <= numx_s7[W_W-1] ^ gsq_s7[W_W-1];
			ds_s8.neg_y <= numy_s7[W_W-1] ^ gsq_s7[W_W-1];
			ds_s8.zero  <= (gsq_s7 == '0);
		end
	end

	// step dividers
	slgs_qdiv u_div_x (
		.clk (clk),
		.en  (en),
		.num (magx_s8),
		.den (magb_s8),
		.quo (qmx_w)
	);

	slgs_qdiv u_div_y (
		.clk (clk),
		.en  (en),
		.num (magy_s8),
		.den (magb_s8),
		.quo (qmy_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dside_q[0] <= ds_s8;
			for (int k = 1; k < Q_BITS; k++) begin
				dside_q[k] <= dside_q[k-1];
			end
		end
	end

	// stage 9: signed quotient, zero divisor gives zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (dside_q[Q_BITS-1].zero) begin
				qx_s9 <= '0;
				qy_s9 <= '0;
			end else begin
				qx_s9 <= dside_q[Q_BITS-1].neg_x ? $signed(W_W'(0) - qmx_w) : $signed(qmx_w);
				qy_s9 <= dside_q[Q_BITS-1].neg_y ? $signed(W_W'(0) - qmy_w) : $signed(qmy_w);
			end
			ds_s9 <= dside_q[Q_BITS-1];
		end
	end

	// stage 10: step = ((q >> F) * 8) >> F
	assign tx_c = ((qx_s9 >>> FRAC_BITS) <<< 3) >>> FRAC_BITS;
	assign ty_c = ((qy_s9 >>> FRAC_BITS) <<< 3) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s10 <= $signed({{W_CX{ds_s9.x[W_C-1]}}, ds_s9.x}) - tx_c;
			ny_s10 <= $signed({{W_CX{ds_s9.y[W_C-1]}}, ds_s9.y}) - ty_c;
			h_s10  <= ds_s9.h;
		end
	end

	// clamp: upper bound first, then lower
	assign lox = $signed({{W_CX{bounds.min_x[W_C-1]}}, bounds.min_x});
	assign hix = $signed({{W_CX{bounds.max_x[W_C-1]}}, bounds.max_x});
	assign loy = $signed({{W_CX{bounds.min_y[W_C-1]}}, bounds.min_y});
	assign hiy = $signed({{W_CX{bounds.max_y[W_C-1]}}, bounds.max_y});

	always_comb begin
		cx_c = (nx_s10 > hix) ? hix : nx_s10;
		cx_c = (lox > cx_c) ? lox : cx_c;
		cy_c = (ny_s10 > hiy) ? hiy : ny_s10;
		cy_c = (loy > cy_c) ? loy : cy_c;
		res_c.nx = cx_c[W_C-1:0];
		res_c.ny = cy_c[W_C-1:0];
		res_c.h  = h_s10;
	end

	// output buffer
	assign ob_push   = en && vld_q[N_STG-1];
	assign out_valid = (ob_cnt_q != 2'd0);
	assign ob_pop    = out_valid && !out_stall;
	assign new_x     = ob_q[ob_rd_q].nx;
	assign new_y     = ob_q[ob_rd_q].ny;
	assign new_h     = ob_q[ob_rd_q].h;

	always_ff @(posedge clk) begin
		if (ob_push) begin
			ob_q[ob_wr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= 1'b0;
			ob_rd_q  <= 1'b0;
			ob_cnt_q <= 2'd0;
		end else begin
			if (ob_push) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			unique case ({ob_push, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 2'd1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 2'd1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

endmodule

### verif/tb_source_location_gradient_step_core.sv
// ---------------------------------------------------------------------------
// tb_source_location_gradient_step_core: self-checking bench for the step core
// Drives position/reading words through the valid/stall channels, predicts
// each stepped and clamped result in 64-bit wrapping arithmetic and compares
// every output word, in order, against the oldest expected word.
// ---------------------------------------------------------------------------
module tb_source_location_gradient_step_core;
	import slgs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [W_C-1:0]  C_MAX  = 24'h7FFFFF;
	localparam logic [W_C-1:0]  C_MIN  = 24'h800000;
	localparam logic [W_RD-1:0] RD_MAX = 22'h1FFFFF;
	localparam logic [W_RD-1:0] RD_MIN = 22'h200000;
	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;
	localparam int ITEMS_PER_SET = 275;
	localparam int DRAIN_CYCLES  = 120;
	localparam int STALL_LIMIT   = 4000;

	typedef struct {
		logic signed [W_C-1:0]  x;
		logic signed [W_C-1:0]  y;
		logic signed [W_C-1:0]  h;
		logic signed [W_RD-1:0] rd;
	} stim_row_t;

	typedef struct {
		stim_row_t      s;
		logic [W_C-1:0] ex;
		logic [W_C-1:0] ey;
	} typed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [W_C-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [W_C-1:0] pos_x = '0, pos_y = '0, pos_h = '0;
	logic signed [W_RD-1:0] light_reading = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [W_C-1:0] new_x, new_y, new_h;

	// predictor copy of the register file
	logic signed [W_C-1:0] m_col, m_row, m_min_x, m_max_x, m_min_y, m_max_y;

	res_t step_q[$];
	int   fail_cnt = 0;
	int   quiet_cycles = 0;
	bit   no_idle = 1'b0;

	// directed words under the reset register values, checked by prediction
	stim_row_t reset_rows [10] = '{
		'{24'sd0, 24'sd0, 24'sd0, 22'sd0},
		'{C_MAX, C_MAX, C_MAX, RD_MAX},
		'{C_MIN, C_MIN, C_MIN, RD_MIN},
		'{C_MAX, C_MIN, 24'sd0, 22'sd0},
		'{C_MIN, C_MAX, C_MAX, RD_MAX},
		'{24'sd0, 24'sd0, 24'sd5000, RD_MAX},   // on the node: no x/y step
		'{24'sd684, 24'sd0, 24'sd1482906, 22'sd0},  // g*g wraps, gsq = 0
		'{24'sd684, 24'sd0, 24'sd1482906, RD_MIN},
		'{24'sd512, -24'sd512, 24'sd1024, 22'sd100000},
		'{24'sd46080, -24'sd15360, 24'sd0, -22'sd100000}
	};

	// inverted box: x lands on min_x, y on min_y, height passes through
	typed_row_t flip_rows [6] = '{
		'{'{24'sd0, 24'sd0, 24'sd0, 22'sd0}, 24'sd1000, 24'sd2000},
		'{'{C_MAX, C_MAX, C_MAX, RD_MAX}, 24'sd1000, 24'sd2000},
		'{'{C_MIN, C_MIN, C_MIN, RD_MIN}, 24'sd1000, 24'sd2000},
		'{'{24'sd1000, 24'sd2000, -24'sd7, 22'sd3}, 24'sd1000, 24'sd2000},
		'{'{-24'sd1000, -24'sd2000, 24'sd99, RD_MAX}, 24'sd1000, 24'sd2000},
		'{'{C_MIN, C_MAX, 24'sd1, RD_MIN}, 24'sd1000, 24'sd2000}
	};

	source_location_gradient_step_core dut (.*);

	always #6 clk = ~clk;

	// receiver stalls at random outside the quiet stretch
	always @(posedge clk) begin
		out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 7);
	end

	// 64-bit truncating division; zero divisor gives zero
	function automatic longint div_trunc(longint a, longint b);
		bit [63:0] ma, mb, q;
		if (b == 0)
			return 0;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		q = ma / mb;
		return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint grad_move(longint c, longint nc, longint df, longint gsq);
		longint q;
		q = div_trunc((longint'(48000) <<< FRAC_BITS) * df * (c - nc), gsq) >>> FRAC_BITS;
		return c - ((8 * q) >>> FRAC_BITS);
	endfunction

	function automatic logic [W_C-1:0] box_clamp(longint v, longint lo, longint hi);
		if (v > hi)
			v = hi;
		if (lo > v)
			v = lo;
		return v[W_C-1:0];
	endfunction

	// expected output word for one input word under the current registers
	function automatic res_t predict_step(stim_row_t s);
		longint dx, dy, hh, g, f, gsq, df;
		res_t r;
		dx = longint'(s.x) - longint'(m_col);
		dy = longint'(s.y) - longint'(m_row);
		hh = longint'(s.h);
		g = ((dx * dx + dy * dy + hh * hh) >>> FRAC_BITS) + (longint'(48) <<< FRAC_BITS);
		f = div_trunc(longint'(48000) <<< (2 * FRAC_BITS), g);
		gsq = (g * g) >>> FRAC_BITS;
		df = longint'(s.rd) - f;
		r.nx = box_clamp(grad_move(s.x, m_col, df, gsq), m_min_x, m_max_x);
		r.ny = box_clamp(grad_move(s.y, m_row, df, gsq), m_min_y, m_max_y);
		r.h = s.h;
		return r;
	endfunction

	// send one word; record its expected result on acceptance
	task automatic send_word(stim_row_t s, bit typed, res_t texp);
		while (!no_idle && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= s.x;
		pos_y <= s.y;
		pos_h <= s.h;
		light_reading <= s.rd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		step_q.push_back(typed ? texp : predict_step(s));
	endtask

	task automatic write_reg(logic [2:0] idx, logic [W_C-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_NODE_COL: m_col = v;
			REG_NODE_ROW: m_row = v;
			REG_MIN_X:    m_min_x = v;
			REG_MAX_X:    m_max_x = v;
			REG_MIN_Y:    m_min_y = v;
			REG_MAX_Y:    m_max_y = v;
			default: ;
		endcase
	endtask

	// let the pipeline empty, then load a full register set
	task automatic load_regs(logic [W_C-1:0] col, row, mnx, mxx, mny, mxy);
		in_valid <= 1'b0;
		wait (step_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_NODE_COL, col);
		write_reg(REG_NODE_ROW, row);
		write_reg(REG_MIN_X, mnx);
		write_reg(REG_MAX_X, mxx);
		write_reg(REG_MIN_Y, mny);
		write_reg(REG_MAX_Y, mxy);
		write_reg(IDX_SPARE_LO, 24'h5A5A5A);
		write_reg(IDX_SPARE_HI, 24'hA5A5A5);
		cfg_we <= 1'b0;
	endtask

	// random words: mostly near the node, some over the full range
	task automatic send_random(int n);
		stim_row_t s;
		res_t none;
		int mode;
		none = '0;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(9);
			if (mode < 6) begin
				s.x = m_col + W_C'($urandom_range(40000) - 20000);
				s.y = m_row + W_C'($urandom_range(40000) - 20000);
				s.h = W_C'($urandom_range(20000) - 10000);
			end else begin
				s.x = W_C'($urandom);
				s.y = W_C'($urandom);
				s.h = W_C'($urandom);
			end
			if ($urandom_range(1))
				s.rd = W_RD'($urandom_range(1200000) - 600000);
			else
				s.rd = W_RD'($urandom);
			send_word(s, 1'b0, none);
		end
	endtask

	// output checker against the oldest expected word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (step_q.size() == 0) begin
				$error("unexpected output word x=%0d y=%0d h=%0d", new_x, new_y, new_h);
				fail_cnt++;
			end else begin
				res_t e;
				e = step_q.pop_front();
				if (new_x !== e.nx) begin
					$error("new_x expected %0d got %0d", $signed(e.nx), new_x);
					fail_cnt++;
				end
				if (new_y !== e.ny) begin
					$error("new_y expected %0d got %0d", $signed(e.ny), new_y);
					fail_cnt++;
				end
				if (new_h !== e.h) begin
					$error("new_h expected %0d got %0d", $signed(e.h), new_h);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog: too long without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		res_t texp;
		res_t none;
		none = '0;
		m_col = '0;
		m_row = '0;
		m_min_x = MIN_RST;
		m_max_x = MAX_RST;
		m_min_y = MIN_RST;
		m_max_y = MAX_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers
		foreach (reset_rows[i])
			send_word(reset_rows[i], 1'b0, none);
		send_random(ITEMS_PER_SET - 10);

		// inverted box
		load_regs(24'sd0, 24'sd0, 24'sd1000, -24'sd1000, 24'sd2000, -24'sd2000);
		foreach (flip_rows[i]) begin
			texp.nx = flip_rows[i].ex;
			texp.ny = flip_rows[i].ey;
			texp.h = flip_rows[i].s.h;
			send_word(flip_rows[i].s, 1'b1, texp);
		end
		send_random(ITEMS_PER_SET - 6);

		// node at the low corner, full box
		load_regs(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX);
		send_random(ITEMS_PER_SET);

		// node at the high corner, full box, no idling on either side
		load_regs(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
		no_idle = 1'b1;
		send_random(ITEMS_PER_SET);
		no_idle = 1'b0;

		// zero-width box
		load_regs(24'sd5120, -24'sd2560, 24'sd300, 24'sd300, -24'sd300, -24'sd300);
		send_random(ITEMS_PER_SET);

		// random registers
		load_regs(W_C'($urandom), W_C'($urandom), W_C'($urandom), W_C'($urandom),
			W_C'($urandom), W_C'($urandom));
		send_random(ITEMS_PER_SET);

		in_valid <= 1'b0;
		wait (step_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
